// ===== rtl/pgag_pkg.sv =====
// Package with shared constants, types and tables of the pooling glyph unit.
package pgag_pkg;

    localparam int MaxWidth = 1024;
    localparam int MaxPool = 8;
    localparam int MaxHeight = 1024;
    localparam int ColW = $clog2(MaxWidth);
    localparam int SlotW = (MaxPool > 1) ? $clog2(MaxPool) : 1;
    localparam int AddrW = ColW + SlotW;
    localparam int Depth = MaxWidth * MaxPool;
    localparam int PixW = 24;
    localparam int SumW = 8 + 2 * $clog2(MaxPool + 1);
    localparam int CfgW = 11;

    localparam logic [17:0] WRed = 18'd19595;
    localparam logic [17:0] WGreen = 18'd38470;
    localparam logic [17:0] WBlue = 18'd7471;

    // Register indexes.
    localparam logic [1:0] RegWidth = 2'd0;
    localparam logic [1:0] RegHeight = 2'd1;
    localparam logic [1:0] RegPool = 2'd2;
    localparam logic [1:0] RegStride = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture pixel, write store, evaluate window
        logic clr_sum;    // clear accumulators and read counters
        logic rd_issue;   // issue a store read for the next window tap
        logic acc;        // not used by the datapath, which adds read data on its registered read valid
        logic div_start;  // start the divide
        logic div_step;   // one restoring divide step
        logic mix;        // luma multiply
        logic fin;        // shift, table lookup, load output register
    } pgag_cmd_t;

    typedef struct packed {
        logic hit;        // the pixel just loaded closes a window
        logic rd_last;    // the current tap is the last of the window
        logic div_last;   // last divide step
        logic busy;       // column and row phases are being rebuilt
    } pgag_sts_t;

    // Glyph ramp lookup.
    function automatic logic [6:0] ramp_glyph(input logic [4:0] idx);
        logic [6:0] g;
        case (idx)
            5'd0: g = 7'd32;   5'd1: g = 7'd46;   5'd2: g = 7'd39;   5'd3: g = 7'd44;
            5'd4: g = 7'd58;   5'd5: g = 7'd59;   5'd6: g = 7'd105;  5'd7: g = 7'd114;
            5'd8: g = 7'd115;  5'd9: g = 7'd88;   5'd10: g = 7'd65;  5'd11: g = 7'd50;
            5'd12: g = 7'd53;  5'd13: g = 7'd51;  5'd14: g = 7'd104; 5'd15: g = 7'd77;
            5'd16: g = 7'd72;  5'd17: g = 7'd71;  5'd18: g = 7'd83;  5'd19: g = 7'd35;
            5'd20: g = 7'd57;  5'd21: g = 7'd66;  5'd22: g = 7'd38;  5'd23: g = 7'd64;
            default: g = 7'd32;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/pgag_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module pgag_ram #(
    parameter int Width = 24,
    parameter int Depth = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/pgag_ctrl.sv =====
// Controller state machine of the pooling glyph unit.
module pgag_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output pgag_pkg::pgag_cmd_t cmd,
    input  pgag_pkg::pgag_sts_t sts
);
    import pgag_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_EVAL, S_READ, S_DRAIN, S_START, S_DIV, S_MIX, S_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   mv_reg, mv_next;
    logic   out_free;

    // Output register frees when its beat is taken.
    assign out_free = !mv_reg || m_ready;
    assign s_ready = (state_reg == S_IDLE) && !sts.busy;
    assign m_valid = mv_reg;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        mv_next = mv_reg && !m_ready;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && !sts.busy) begin
                    cmd.load = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.clr_sum = 1'b1;
                state_next = sts.hit ? S_READ : S_IDLE;
            end
            S_READ: begin
                cmd.rd_issue = 1'b1;
                if (sts.rd_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                cmd.acc = 1'b1;
                state_next = S_START;
            end
            S_START: begin
                cmd.div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_MIX;
                end
            end
            S_MIX: begin
                cmd.mix = 1'b1;
                state_next = S_HOLD;
            end
            S_HOLD: begin
                if (out_free) begin
                    cmd.fin = 1'b1;
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // Hold acc low in S_READ while taps remain to be read.
        if (state_reg == S_READ && !sts.rd_last) begin
            cmd.acc = 1'b0;
        end
    end

    // State and registered valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
        end
    end

    // A result is loaded only when the output register is free.
    a_fin_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |-> out_free) else $error("result loaded over a pending beat");
    // No pixel is taken while a window is in work.
    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !cmd.load) else $error("load while busy");
    // A pending result holds until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_ready) |=> mv_reg) else $error("result dropped");
endmodule

// ===== rtl/pgag_dp.sv =====
// Datapath: counters, line store, window sums, divider, luma and glyph.
module pgag_dp (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [pgag_pkg::CfgW-1:0] cfg_data,
    input  logic [7:0]               s_red,
    input  logic [7:0]               s_green,
    input  logic [7:0]               s_blue,
    output logic [7:0]               m_grey,
    output logic [6:0]               m_glyph,
    output logic                     m_row_end,
    output logic                     m_frame_end,
    input  pgag_pkg::pgag_cmd_t      cmd,
    output pgag_pkg::pgag_sts_t      sts
);
    import pgag_pkg::*;

    logic [10:0] width_reg, height_reg;
    logic [3:0]  pool_reg, stride_reg;
    logic [ColW-1:0] col_reg;
    logic [9:0]  row_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= 11'd64;
            height_reg <= 11'd64;
            pool_reg <= 4'd2;
            stride_reg <= 4'd2;
        end else if (cfg_we) begin
            unique case (cfg_index)
                RegWidth: width_reg <= cfg_data[10:0];
                RegHeight: height_reg <= cfg_data[10:0];
                RegPool: pool_reg <= cfg_data[3:0];
                RegStride: stride_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Saturated settings.
    logic [10:0] w, h;
    logic [3:0]  p, s;
    always_comb begin
        w = (width_reg == 11'd0) ? 11'd1 : (width_reg > 11'(MaxWidth)) ? 11'(MaxWidth) : width_reg;
        h = (height_reg == 11'd0) ? 11'd1
          : (height_reg > 11'(MaxHeight)) ? 11'(MaxHeight) : height_reg;
        p = (pool_reg == 4'd0) ? 4'd1 : (pool_reg > 4'(MaxPool)) ? 4'(MaxPool) : pool_reg;
        s = (stride_reg == 4'd0) ? 4'd1 : stride_reg;
    end

    // Window origin tracking.
    logic [10:0] ox_reg, oy_reg;
    logic        hit_reg, rowe_reg, fre_reg;
    logic [11:0] c1, r1;
    assign c1 = 12'(col_reg) + 12'd1;
    assign r1 = 12'(row_reg) + 12'd1;

    // The phase checks use the small modulo by stride kept in counters:
    // phase of a position x is x mod s, tracked alongside the counters.
    logic [3:0] cmod_reg, rmod_reg;  // col mod s, row mod s
    logic [3:0] pm;                  // (p-1) mod s
    always_comb begin
        pm = p - 4'd1;
        for (int k = 0; k < 8; k++) begin
            if (pm >= s) pm = pm - s;
        end
    end

    logic hit_c;
    logic [ColW-1:0] ox_c;
    logic [9:0] oy_c;
    assign ox_c = ColW'(c1 - 12'(p));
    assign oy_c = 10'(r1 - 12'(p));
    assign hit_c = (c1 >= 12'(p)) && (r1 >= 12'(p)) && (cmod_reg == pm) && (rmod_reg == pm)
                 && (12'(col_reg) < 12'(w)) && (12'(row_reg) < 12'(h));

    // Pixel capture, store write, counter update.
    logic [PixW-1:0] pix;
    assign pix = {s_red, s_green, s_blue};
    logic [3:0] cmod_inc, rmod_inc;
    assign cmod_inc = (cmod_reg + 4'd1 >= s) ? 4'd0 : cmod_reg + 4'd1;
    assign rmod_inc = (rmod_reg + 4'd1 >= s) ? 4'd0 : rmod_reg + 4'd1;

    // After a stride write the phases are rebuilt bit by bit from the counters.
    logic       rem_busy_reg;
    logic [3:0] rem_cnt_reg;
    logic [9:0] csh_reg, rsh_reg;
    logic [4:0] crt, rrt;
    assign crt = {cmod_reg, csh_reg[9]};
    assign rrt = {rmod_reg, rsh_reg[9]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            cmod_reg <= '0;
            rmod_reg <= '0;
            hit_reg <= 1'b0;
            csh_reg <= '0;
            rsh_reg <= '0;
            rem_cnt_reg <= '0;
            rem_busy_reg <= 1'b0;
        end else if (cfg_we && (cfg_index == RegStride)) begin
            cmod_reg <= '0;
            rmod_reg <= '0;
            csh_reg <= 10'(col_reg);
            rsh_reg <= row_reg;
            rem_cnt_reg <= 4'd10;
            rem_busy_reg <= 1'b1;
        end else if (rem_busy_reg) begin
            cmod_reg <= (crt >= 5'(s)) ? 4'(crt - 5'(s)) : crt[3:0];
            rmod_reg <= (rrt >= 5'(s)) ? 4'(rrt - 5'(s)) : rrt[3:0];
            csh_reg <= {csh_reg[8:0], 1'b0};
            rsh_reg <= {rsh_reg[8:0], 1'b0};
            rem_cnt_reg <= rem_cnt_reg - 4'd1;
            rem_busy_reg <= (rem_cnt_reg != 4'd1);
        end else if (cmd.load) begin
            hit_reg <= hit_c;
            if (c1 >= 12'(w)) begin
                col_reg <= '0;
                cmod_reg <= '0;
                if (r1 >= 12'(h)) begin
                    row_reg <= '0;
                    rmod_reg <= '0;
                end else begin
                    row_reg <= 10'(r1);
                    rmod_reg <= rmod_inc;
                end
            end else begin
                col_reg <= ColW'(c1);
                cmod_reg <= cmod_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ox_reg <= 11'(ox_c);
            oy_reg <= 11'(oy_c);
            rowe_reg <= (12'(ox_c) + 12'(s) + 12'(p)) > 12'(w);
            fre_reg <= ((12'(ox_c) + 12'(s) + 12'(p)) > 12'(w))
                    && ((12'(oy_c) + 12'(s) + 12'(p)) > 12'(h));
        end
    end

    // Tap walk over the window.
    logic [3:0] ti_reg, tj_reg;
    logic       last_tap;
    assign last_tap = (ti_reg == p - 4'd1) && (tj_reg == p - 4'd1);
    logic [AddrW-1:0] raddr, waddr;
    logic [ColW-1:0] rcol;
    logic [9:0] rrow;
    assign rcol = ColW'(ox_reg + 11'(ti_reg));
    assign rrow = 10'(oy_reg + 11'(tj_reg));
    assign raddr = {rrow[SlotW-1:0], rcol};
    assign waddr = {row_reg[SlotW-1:0], col_reg};

    logic [PixW-1:0] rdata;
    logic            rv_reg;

    pgag_ram #(.Width(PixW), .Depth(Depth)) u_store (
        .aclk(aclk), .we(cmd.load), .waddr(waddr), .wdata(pix),
        .re(cmd.rd_issue), .raddr(raddr), .rdata(rdata)
    );

    logic [SumW-1:0] sr_reg, sg_reg, sb_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg <= 1'b0;
        end else begin
            rv_reg <= cmd.rd_issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_sum) begin
            ti_reg <= '0;
            tj_reg <= '0;
            sr_reg <= '0;
            sg_reg <= '0;
            sb_reg <= '0;
        end else begin
            if (cmd.rd_issue) begin
                if (ti_reg == p - 4'd1) begin
                    ti_reg <= '0;
                    tj_reg <= tj_reg + 4'd1;
                end else begin
                    ti_reg <= ti_reg + 4'd1;
                end
            end
            if (rv_reg) begin
                sr_reg <= sr_reg + SumW'(rdata[23:16]);
                sg_reg <= sg_reg + SumW'(rdata[15:8]);
                sb_reg <= sb_reg + SumW'(rdata[7:0]);
            end
        end
    end

    // Restoring divide of the three sums by p*p, one quotient bit a step.
    logic [6:0] d;
    assign d = 7'(p) * 7'(p);
    logic [SumW-1:0] qr_reg, qg_reg, qb_reg;
    logic [6:0] rr_reg, rg_reg, rb_reg;
    logic [3:0] dc_reg;
    logic [7:0] rt_r, rt_g, rt_b;
    assign rt_r = {rr_reg, qr_reg[SumW-1]};
    assign rt_g = {rg_reg, qg_reg[SumW-1]};
    assign rt_b = {rb_reg, qb_reg[SumW-1]};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            qr_reg <= sr_reg;
            qg_reg <= sg_reg;
            qb_reg <= sb_reg;
            rr_reg <= '0;
            rg_reg <= '0;
            rb_reg <= '0;
            dc_reg <= '0;
        end else if (cmd.div_step) begin
            dc_reg <= dc_reg + 4'd1;
            rr_reg <= 7'((rt_r >= 8'(d)) ? rt_r - 8'(d) : rt_r);
            rg_reg <= 7'((rt_g >= 8'(d)) ? rt_g - 8'(d) : rt_g);
            rb_reg <= 7'((rt_b >= 8'(d)) ? rt_b - 8'(d) : rt_b);
            qr_reg <= {qr_reg[SumW-2:0], rt_r >= 8'(d)};
            qg_reg <= {qg_reg[SumW-2:0], rt_g >= 8'(d)};
            qb_reg <= {qb_reg[SumW-2:0], rt_b >= 8'(d)};
        end
    end

    // Luma products, registered before the sum and shift.
    logic [25:0] pr_reg, pg_reg, pb_reg;
    always_ff @(posedge aclk) begin
        if (cmd.mix) begin
            pr_reg <= 26'(qr_reg[7:0]) * 26'(WRed);
            pg_reg <= 26'(qg_reg[7:0]) * 26'(WGreen);
            pb_reg <= 26'(qb_reg[7:0]) * 26'(WBlue);
        end
    end

    logic [25:0] lsum;
    logic [7:0]  grey_c;
    logic [12:0] gi;
    assign lsum = pr_reg + pg_reg + pb_reg;
    assign grey_c = (lsum[25:24] != 2'd0) ? 8'd255 : lsum[23:16];
    assign gi = 13'(grey_c) * 13'd24;

    // Output register.
    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            m_grey <= grey_c;
            m_glyph <= ramp_glyph(gi[12:8]);
            m_row_end <= rowe_reg;
            m_frame_end <= fre_reg;
        end
    end

    assign sts.hit = hit_reg;
    assign sts.rd_last = last_tap;
    assign sts.div_last = (dc_reg == 4'(SumW - 1));
    assign sts.busy = rem_busy_reg;

    logic unused;
    assign unused = cmd.acc;

    // The tap walk never runs past the window.
    a_tap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |-> (ti_reg < p) && (tj_reg < p)) else $error("tap out of window");
    // The red quotient fits eight bits after the last step.
    a_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mix |-> (qr_reg[SumW-1:8] == '0)) else $error("average overflow");
    // Column counter stays within the store row.
    a_col: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (12'(col_reg) < 12'(MaxWidth))) else $error("column overflow");
endmodule

// ===== rtl/pool_grey_ascii_glyph_unit.sv =====
// Top level of the pooling glyph unit: controller plus datapath.
//  channel | ports                                   | handshake
//  input   | s_red, s_green, s_blue                  | s_valid / s_ready
//  result  | m_grey, m_glyph, m_row_end, m_frame_end | m_valid / m_ready
//  config  | cfg_we, cfg_index, cfg_data             | write enable only
// A pixel that closes no window passes through S_EVAL only; one that closes a p by p
// window also has its p*p taps read through the single store read port and then
// goes through the bit-serial divider before the next pixel is taken.
// A stride write holds the input off while the phases rebuild.
// Reset is synchronous and active low; the line store has no reset.
// A result waits in the output register while the next pixel is taken.
module pool_grey_ascii_glyph_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [pgag_pkg::CfgW-1:0] cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_red,
    input  logic [7:0]                s_green,
    input  logic [7:0]                s_blue,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_grey,
    output logic [6:0]                m_glyph,
    output logic                      m_row_end,
    output logic                      m_frame_end
);
    import pgag_pkg::*;

    pgag_cmd_t cmd;
    pgag_sts_t sts;

    pgag_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .sts(sts)
    );

    pgag_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_red(s_red), .s_green(s_green), .s_blue(s_blue),
        .m_grey(m_grey), .m_glyph(m_glyph), .m_row_end(m_row_end),
        .m_frame_end(m_frame_end), .cmd(cmd), .sts(sts)
    );
endmodule
